>>> design/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

  // Default pattern capacity in bytes
  localparam int unsigned MAX_PATTERN_DEF = 64;

  // Command codes carried in the slave tuser field
  localparam logic [1:0] CMD_NEW_PATTERN = 2'd0;
  localparam logic [1:0] CMD_APPEND      = 2'd1;
  localparam logic [1:0] CMD_TEXT        = 2'd2;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned POS_W    = 32;

endpackage

`default_nettype wire

>>> design/kmp_stream_matcher_unit.sv
`default_nettype none

// Streaming Knuth-Morris-Pratt matcher. Every slave transaction carries a
// command in tuser (0 start a new pattern with this byte, 1 append a pattern
// byte, 2 text byte) and a byte in tdata, and yields exactly one master
// transaction. Pattern bytes are kept in an on-chip memory of MaxPattern
// entries together with their failure-function entries, which are built as
// the bytes arrive; bytes beyond capacity are dropped and flagged. Text bytes
// advance the match and report the zero-based start of each occurrence
// (overlaps included); the text position counter wraps at 2^32 and is cleared
// by command 0. Each transaction is handled by a small sequencer around one
// compare unit and one read port per memory: every compare/fallback step is a
// memory read followed by a compare (StRd, then StCmp). A text byte that
// follows a full match first reads the failure entry of the whole pattern
// (StFRd, StFLd), and commands that need no search go straight to StDone.
// Fallbacks are amortized. The slave side is ready only while the sequencer
// is idle; a result waits in the master output register until taken.
module kmp_stream_matcher_unit #(
  parameter int unsigned MaxPattern = kmp_pkg::MAX_PATTERN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] match_start
  output logic [1:0]       m_axis_tuser    // [0] match_found, [1] pattern_full
);

  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned LenW = $clog2(MaxPattern + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPattern);

  // sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFRd  = 3'd1;  // read failure entry of whole pattern
  localparam logic [2:0] StFLd  = 3'd2;  // take it as the start length
  localparam logic [2:0] StRd   = 3'd3;  // read pattern/failure at k
  localparam logic [2:0] StCmp  = 3'd4;  // compare and step
  localparam logic [2:0] StDone = 3'd5;  // hand result to output register

  logic [2:0] state_q, state_d;

  // block state
  logic [LenW-1:0] plen_q, plen_d;
  logic [LenW-1:0] mlen_q, mlen_d;
  logic [IdxW-1:0] build_q, build_d;
  logic [kmp_pkg::POS_W-1:0] tpos_q, tpos_d;

  // working registers
  logic [LenW-1:0] k_q, k_d;
  logic [kmp_pkg::SYMBOL_W-1:0] sym_q, sym_d;
  logic text_q, text_d;

  // pending result
  logic res_found_q, res_found_d;
  logic res_full_q, res_full_d;
  logic [kmp_pkg::POS_W-1:0] res_start_q, res_start_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic [31:0] out_start_q, out_start_d;
  logic out_found_q, out_found_d;
  logic out_full_q, out_full_d;

  // memories
  logic [7:0]      pat_mem  [MaxPattern];
  logic [IdxW-1:0] fail_mem [MaxPattern];
  logic [7:0]      pat_rd_q;
  logic [IdxW-1:0] fail_rd_q;
  logic [IdxW-1:0] pat_raddr, fail_raddr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [7:0]      wr_pat;
  logic [IdxW-1:0] wr_fail;

  logic            accept;
  logic [LenW-1:0] fail_ext;
  logic [LenW-1:0] k_step;
  logic            sym_hit;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_start_q;
  assign m_axis_tuser  = {out_full_q, out_found_q};

  // read addresses
  assign pat_raddr  = k_q[IdxW-1:0];
  assign fail_raddr = (state_q == StFRd) ? IdxW'(plen_q - LenW'(1))
                                         : IdxW'(k_q - LenW'(1));

  // shared compare unit
  assign fail_ext = LenW'(fail_rd_q);
  assign sym_hit  = (pat_rd_q == sym_q);
  assign k_step   = k_q + LenW'(1);

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pat_mem[wr_addr]  <= wr_pat;
      fail_mem[wr_addr] <= wr_fail;
    end
    pat_rd_q  <= pat_mem[pat_raddr];
    fail_rd_q <= fail_mem[fail_raddr];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    plen_d      = plen_q;
    mlen_d      = mlen_q;
    build_d     = build_q;
    tpos_d      = tpos_q;
    k_d         = k_q;
    sym_d       = sym_q;
    text_d      = text_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_start_d = res_start_q;
    out_valid_d = out_valid_q;
    out_start_d = out_start_q;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_pat      = sym_q;
    wr_fail     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          sym_d       = s_axis_tdata;
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          res_start_d = '0;
          state_d     = StDone;
          if (s_axis_tuser == kmp_pkg::CMD_NEW_PATTERN ||
              (s_axis_tuser == kmp_pkg::CMD_APPEND && plen_q == '0)) begin
            if (s_axis_tuser == kmp_pkg::CMD_NEW_PATTERN) begin
              mlen_d = '0;
              tpos_d = '0;
            end
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_pat  = s_axis_tdata;
            wr_fail = '0;
            plen_d  = LenW'(1);
            build_d = '0;
          end else if (s_axis_tuser == kmp_pkg::CMD_APPEND) begin
            if (plen_q >= MaxLen) begin
              res_full_d = 1'b1;
            end else begin
              text_d  = 1'b0;
              k_d     = LenW'(build_q);
              state_d = StRd;
            end
          end else if (s_axis_tuser == kmp_pkg::CMD_TEXT) begin
            tpos_d = tpos_q + kmp_pkg::POS_W'(1);
            if (plen_q != '0) begin
              text_d = 1'b1;
              if (mlen_q >= plen_q) begin
                state_d = StFRd;
              end else begin
                k_d     = mlen_q;
                state_d = StRd;
              end
            end
          end
        end
      end
      StFRd: begin
        state_d = StFLd;
      end
      StFLd: begin
        k_d     = fail_ext;
        state_d = StRd;
      end
      StRd: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (k_q != '0 && !sym_hit) begin
          // mismatch: fall back through the failure table
          k_d     = (fail_ext < k_q) ? fail_ext : '0;
          state_d = StRd;
        end else begin
          k_d = sym_hit ? k_step : k_q;
          state_d = StDone;
          if (text_q) begin
            mlen_d = k_d;
            if (k_d == plen_q) begin
              res_found_d = 1'b1;
              res_start_d = tpos_q - kmp_pkg::POS_W'(plen_q);
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = plen_q[IdxW-1:0];
            wr_pat  = sym_q;
            wr_fail = k_d[IdxW-1:0];
            build_d = k_d[IdxW-1:0];
            plen_d  = plen_q + LenW'(1);
          end
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_start_d = res_start_q;
          out_found_d = res_found_q;
          out_full_d  = res_full_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      plen_q      <= '0;
      mlen_q      <= '0;
      build_q     <= '0;
      tpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      mlen_q      <= mlen_d;
      build_q     <= build_d;
      tpos_q      <= tpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    sym_q       <= sym_d;
    text_q      <= text_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    res_start_q <= res_start_d;
    out_start_q <= out_start_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
  end

  // checks
  a_match_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mlen_q <= plen_q)
    else $error("match length exceeds pattern length");

  a_build_lt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plen_q != '0) |-> (LenW'(build_q) < plen_q))
    else $error("build length not below pattern length");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |-> (k_q < plen_q))
    else $error("search index beyond pattern");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_found_q && out_full_q))
    else $error("match and overflow flagged together");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && (!out_valid_q || m_axis_tready)) |=>
      (out_valid_q && state_q == StIdle))
    else $error("result not delivered to output register");

endmodule

`default_nettype wire

>>> tb/sv/kmp_stream_matcher_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the matcher, predicts one result per
// accepted input transaction and compares each output transaction with the
// oldest prediction.
module kmp_stream_matcher_checker #(
  parameter int unsigned MaxPattern = kmp_pkg::MAX_PATTERN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,   // [31:0] match_start
  input  wire logic [1:0]  m_axis_tuser,   // [0] match_found, [1] pattern_full
  output int unsigned      error_cnt_o,
  output int unsigned      pending_cnt_o,
  output int unsigned      result_cnt_o,
  output int unsigned      occurrence_cnt_o,
  output int unsigned      dropped_cnt_o
);

  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic        full;
  } match_result_t;

  // Predicted matcher state
  logic [7:0]      pat_bytes [MaxPattern];
  logic [LenW-1:0] fail_len  [MaxPattern];
  logic [LenW-1:0] pat_len;
  logic [LenW-1:0] match_len;
  logic [LenW-1:0] build_len;
  logic [31:0]     text_pos;

  match_result_t expected_q[$];

  // Extend a matched prefix of length k by byte b, falling back on mismatch
  function automatic logic [LenW-1:0] extend_prefix(logic [LenW-1:0] k, logic [7:0] b);
    logic [LenW-1:0] f;
    while (k > 0 && pat_bytes[k[IdxW-1:0]] != b) begin
      f = fail_len[IdxW'(k - 1'b1)];
      k = (f < k) ? f : '0;
    end
    if (pat_bytes[k[IdxW-1:0]] == b) begin
      k = k + 1'b1;
    end
    return k;
  endfunction

  // Apply one input transaction to the predicted state and return its result
  function automatic match_result_t predict_item(logic [1:0] cmd, logic [7:0] b);
    match_result_t r;
    logic [LenW-1:0] k;
    r = '0;
    if (cmd == kmp_pkg::CMD_NEW_PATTERN ||
        (cmd == kmp_pkg::CMD_APPEND && pat_len == 0)) begin
      // an append to an empty pattern keeps the search position
      if (cmd == kmp_pkg::CMD_NEW_PATTERN) begin
        match_len = '0;
        text_pos  = '0;
      end
      pat_bytes[0] = b;
      fail_len[0]  = '0;
      pat_len      = LenW'(1);
      build_len    = '0;
    end else if (cmd == kmp_pkg::CMD_APPEND) begin
      if (pat_len >= MaxPattern) begin
        r.full = 1'b1;
      end else begin
        k = extend_prefix(build_len, b);
        pat_bytes[pat_len[IdxW-1:0]] = b;
        fail_len[pat_len[IdxW-1:0]]  = k;
        build_len                    = k;
        pat_len                      = pat_len + 1'b1;
      end
    end else if (cmd == kmp_pkg::CMD_TEXT) begin
      if (pat_len > 0) begin
        k = match_len;
        // restart from the border of the whole pattern after a full match
        if (k >= pat_len) begin
          k = fail_len[IdxW'(pat_len - 1'b1)];
        end
        k = extend_prefix(k, b);
        match_len = k;
        if (k == pat_len) begin
          r.found = 1'b1;
          r.start = text_pos - 32'(pat_len) + 32'd1;
        end
      end
      text_pos = text_pos + 32'd1;
    end
    return r;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin : compare_proc
    match_result_t exp_r;
    match_result_t got_r;
    if (!rst_ni) begin
      for (int i = 0; i < MaxPattern; i++) begin
        pat_bytes[i] = '0;
        fail_len[i]  = '0;
      end
      pat_len   = '0;
      match_len = '0;
      build_len = '0;
      text_pos  = '0;
      expected_q.delete();
      error_cnt_o      = 0;
      pending_cnt_o    = 0;
      result_cnt_o     = 0;
      occurrence_cnt_o = 0;
      dropped_cnt_o    = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_item(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.found = m_axis_tuser[0];
        got_r.start = m_axis_tdata;
        got_r.full  = m_axis_tuser[1];
        result_cnt_o++;
        if (got_r.found) occurrence_cnt_o++;
        if (got_r.full) dropped_cnt_o++;
        if (expected_q.size() == 0) begin
          error_cnt_o++;
          $display("%0t: unexpected result, expected none, got found=%0b start=%0d full=%0b",
                   $time, got_r.found, got_r.start, got_r.full);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.found !== exp_r.found) begin
            error_cnt_o++;
            $display("%0t: match_found mismatch, expected %0b, got %0b",
                     $time, exp_r.found, got_r.found);
          end
          if (got_r.start !== exp_r.start) begin
            error_cnt_o++;
            $display("%0t: match_start mismatch, expected %0d, got %0d",
                     $time, exp_r.start, got_r.start);
          end
          if (got_r.full !== exp_r.full) begin
            error_cnt_o++;
            $display("%0t: pattern_full mismatch, expected %0b, got %0b",
                     $time, exp_r.full, got_r.full);
          end
        end
      end
      pending_cnt_o = expected_q.size();
    end
  end

endmodule

>>> tb/sv/kmp_stream_matcher_unit_tb.sv
`timescale 1ns / 100ps

module kmp_stream_matcher_unit_tb;

  localparam int unsigned MaxPattern  = kmp_pkg::MAX_PATTERN_DEF;
  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam int unsigned ItemTarget  = 1850;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned IdleLimit   = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned error_cnt;
  int unsigned pending_cnt;
  int unsigned result_cnt;
  int unsigned occurrence_cnt;
  int unsigned dropped_cnt;

  int unsigned items_sent = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_off_req = 1'b0;

  kmp_stream_matcher_unit #(
    .MaxPattern(MaxPattern)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  kmp_stream_matcher_checker #(
    .MaxPattern(MaxPattern)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .error_cnt_o     (error_cnt),
    .pending_cnt_o   (pending_cnt),
    .result_cnt_o    (result_cnt),
    .occurrence_cnt_o(occurrence_cnt),
    .dropped_cnt_o   (dropped_cnt)
  );

  // 10 ns clock
  initial begin : clock_gen
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Idle length: mostly none, some short, a few long; none in quiet phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One input transaction, driven at the falling edge, held until accepted
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] sym);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= sym;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        stall_left = HoldCycles - 1;
        hold_off_req = 1'b0;
      end else begin
        stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Ends the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, IdleLimit);
    $display("** kmp_stream_matcher_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  alphabet [4];
    logic [7:0]  pattern  [MaxPattern];
    int unsigned asz;
    int unsigned plen;
    int unsigned tlen;
    int unsigned n;
    int unsigned r;
    int unsigned seq_idx;
    logic [7:0]  sym;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: text with no pattern, append to an empty pattern, reserved
    // command, byte after a full match, fallback on a mismatch, one-byte pattern
    send_item(kmp_pkg::CMD_TEXT, 8'h00);
    send_item(kmp_pkg::CMD_TEXT, 8'hFF);
    send_item(kmp_pkg::CMD_APPEND, 8'hFF);
    send_item(kmp_pkg::CMD_APPEND, 8'h00);
    send_item(kmp_pkg::CMD_TEXT, 8'hFF);
    send_item(kmp_pkg::CMD_TEXT, 8'h00);
    send_item(CMD_RESERVED, 8'hA5);
    send_item(kmp_pkg::CMD_TEXT, 8'h00);
    send_item(kmp_pkg::CMD_NEW_PATTERN, 8'h61);
    send_item(kmp_pkg::CMD_APPEND, 8'h61);
    send_item(kmp_pkg::CMD_APPEND, 8'h62);
    send_item(kmp_pkg::CMD_TEXT, 8'h61);
    send_item(kmp_pkg::CMD_TEXT, 8'h61);
    send_item(kmp_pkg::CMD_TEXT, 8'h61);
    send_item(kmp_pkg::CMD_TEXT, 8'h62);
    send_item(kmp_pkg::CMD_TEXT, 8'h61);
    send_item(kmp_pkg::CMD_TEXT, 8'h61);
    send_item(kmp_pkg::CMD_TEXT, 8'h62);
    send_item(kmp_pkg::CMD_NEW_PATTERN, 8'h5A);
    send_item(kmp_pkg::CMD_TEXT, 8'h5A);
    send_item(kmp_pkg::CMD_TEXT, 8'h5A);
    send_item(CMD_RESERVED, 8'h00);

    // Random: a pattern over a small alphabet, then text seeded with copies
    asz = 1;
    plen = 0;
    seq_idx = 0;
    while (items_sent < ItemTarget) begin
      quiet_phase = ($urandom_range(0, 4) == 0);
      if (seq_idx == 3) hold_off_req = 1'b1;

      // now and then keep searching with the previous pattern
      if (seq_idx == 0 || plen == 0 || $urandom_range(0, 9) != 0) begin
        asz = $urandom_range(1, 4);
        for (int i = 0; i < asz; i++) alphabet[i] = 8'($urandom_range(0, 255));
        if (seq_idx == 0) begin
          plen = MaxPattern;
        end else if ($urandom_range(0, 11) == 0) begin
          plen = $urandom_range(40, MaxPattern);
        end else begin
          plen = $urandom_range(1, 6);
        end
        for (int i = 0; i < plen; i++) pattern[i] = alphabet[$urandom_range(0, asz - 1)];
        send_item(kmp_pkg::CMD_NEW_PATTERN, pattern[0]);
        for (int i = 1; i < plen; i++) send_item(kmp_pkg::CMD_APPEND, pattern[i]);
        // bytes past capacity get dropped
        if (plen == MaxPattern) begin
          repeat ($urandom_range(1, 3)) begin
            send_item(kmp_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
          end
        end
      end

      tlen = $urandom_range(10, 50);
      n = 0;
      while (n < tlen) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          for (int i = 0; i < plen; i++) send_item(kmp_pkg::CMD_TEXT, pattern[i]);
          n += plen;
        end else if (r < 92) begin
          send_item(kmp_pkg::CMD_TEXT, alphabet[$urandom_range(0, asz - 1)]);
          n++;
        end else if (r < 96) begin
          send_item(kmp_pkg::CMD_TEXT, 8'($urandom_range(0, 255)));
          n++;
        end else if (r < 98) begin
          send_item(CMD_RESERVED, 8'($urandom_range(0, 255)));
        end else begin
          // pattern grows in the middle of the search
          sym = alphabet[$urandom_range(0, asz - 1)];
          send_item(kmp_pkg::CMD_APPEND, sym);
          if (plen < MaxPattern) begin
            pattern[plen] = sym;
            plen++;
          end
        end
      end
      seq_idx++;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain: all predictions consumed, then let the block settle
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Stimulus: %0d input transactions over %0d pattern/text sequences.",
             items_sent, seq_idx);
    $display("Checked %0d results: %0d occurrences reported, %0d pattern bytes dropped.",
             result_cnt, occurrence_cnt, dropped_cnt);
    if (error_cnt == 0) begin
      $display("** kmp_stream_matcher_unit: PASSED **");
    end else begin
      $display("** kmp_stream_matcher_unit: FAILED **");
    end
    $finish;
  end

endmodule
